[rtl/sqb_pkg.sv]
// ----------------------------------------------------------------------------
// sqb_pkg
// Shared types and constants for the sprite quad batcher.
// ----------------------------------------------------------------------------
package sqb_pkg;

  localparam int MAX_BATCH_QUADS = 8192;
  localparam int TEXTURE_SLOTS   = 8;

  // input kinds
  localparam logic [1:0] KIND_SPRITE = 2'd0;
  localparam logic [1:0] KIND_BEGIN  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // result kinds
  localparam logic [1:0] OUT_VERTEX = 2'd0;
  localparam logic [1:0] OUT_BIND   = 2'd1;
  localparam logic [1:0] OUT_DRAW   = 2'd2;

  localparam logic [15:0] INDEX_BUDGET = 16'(6 * MAX_BATCH_QUADS);
  localparam logic [3:0]  SLOT_COUNT   = 4'(TEXTURE_SLOTS);
  localparam logic [16:0] TEX_MAX      = 17'h1FFFF;
  localparam logic [16:0] TEX_ONE      = 17'h10000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        texture_id;
    logic [12:0]        texture_width;
    logic [12:0]        texture_height;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [11:0]        cell_width;
    logic [11:0]        cell_height;
    logic [11:0]        cell_col;
    logic [11:0]        cell_row;
  } sqb_in_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [2:0]         slot;
    logic [31:0]        bound_texture;
    logic [15:0]        draw_indices;
    logic               last;
  } sqb_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        texture_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [12:0]        size_x;
    logic [12:0]        size_y;
    logic [16:0]        u0;
    logic [16:0]        u1;
    logic [16:0]        v0;
    logic [16:0]        v1;
  } sqb_item_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_LOAD, F_DIV, F_PUSH
  } sqb_front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_START, B_FLUSH, B_LOOK, B_BIND, B_DRAW, B_VERT
  } sqb_back_state_t;

endpackage

[rtl/sqb_div.sv]
// ----------------------------------------------------------------------------
// sqb_div
// Restoring divider for one texture coordinate: (num << 16) / den, saturated.
// ----------------------------------------------------------------------------
module sqb_div import sqb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] num,
  input  logic [12:0] den,
  output logic        busy,
  output logic [16:0] quot
);

  logic [4:0]  cnt;
  logic [12:0] rem;
  logic [12:0] den_r;
  logic        low_bit;
  logic [13:0] trial;
  logic        fits;

  // one quotient bit per cycle
  assign trial = {rem, (cnt == 5'd17) ? low_bit : 1'b0};
  assign fits  = trial >= {1'b0, den_r};
  assign busy  = cnt != 5'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 5'd0;
    end else if (start) begin
      if (den == 13'd0 || {1'b0, num} >= {11'd0, den, 1'b0}) begin
        cnt <= 5'd0;
      end else begin
        cnt <= 5'd17;
      end
    end else if (busy) begin
      cnt <= cnt - 5'd1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      den_r   <= den;
      low_bit <= num[0];
      rem     <= num[13:1];
      if (den == 13'd0) begin
        quot <= (num != 24'd0) ? TEX_MAX : 17'd0;
      end else if ({1'b0, num} >= {11'd0, den, 1'b0}) begin
        quot <= TEX_MAX;
      end else begin
        quot <= 17'd0;
      end
    end else if (busy) begin
      rem  <= fits ? 13'(trial - {1'b0, den_r}) : trial[12:0];
      quot <= {quot[15:0], fits};
    end
  end

endmodule

[rtl/sqb_front.sv]
// ----------------------------------------------------------------------------
// sqb_front
// Accepts items, works out quad size and atlas coordinates, queues the result.
// ----------------------------------------------------------------------------
module sqb_front import sqb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  sqb_in_t   item,
  output logic      q_push,
  input  logic      q_full,
  output sqb_item_t q_item
);

  sqb_front_state_t state, state_next;
  sqb_in_t          cur;
  logic [23:0]      num [4];
  logic [16:0]      quot [4];
  logic [3:0]       busy;
  logic [12:0]      den [4];
  logic             div_start;
  logic             cell_mode;
  logic             accept;

  assign cell_mode = (cur.cell_width != 12'd0) || (cur.cell_height != 12'd0);
  assign accept    = push && !full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept) state_next = F_MUL;
      F_MUL:  state_next = (cur.kind == KIND_SPRITE && cell_mode) ? F_LOAD : F_PUSH;
      F_LOAD: state_next = F_DIV;
      F_DIV:  if (busy == 4'd0) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full      = 1'b1;
    div_start = 1'b0;
    q_push    = 1'b0;
    case (state)
      F_IDLE:  full = 1'b0;
      F_LOAD:  div_start = 1'b1;
      F_PUSH:  q_push = !q_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture item and products
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    if (state == F_MUL) begin
      num[0] <= 24'(cur.cell_col * cur.cell_width);
      num[1] <= 24'(({1'b0, cur.cell_col} + 13'd1) * cur.cell_width);
      num[2] <= 24'(cur.cell_row * cur.cell_height);
      num[3] <= 24'(({1'b0, cur.cell_row} + 13'd1) * cur.cell_height);
    end
  end

  assign den[0] = cur.texture_width;
  assign den[1] = cur.texture_width;
  assign den[2] = cur.texture_height;
  assign den[3] = cur.texture_height;

  // one divider lane per coordinate
  for (genvar g = 0; g < 4; g++) begin : g_lane
    sqb_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (num[g]),
      .den   (den[g]),
      .busy  (busy[g]),
      .quot  (quot[g])
    );
  end

  // assemble queued item
  always_comb begin
    q_item.kind       = cur.kind;
    q_item.texture_id = cur.texture_id;
    q_item.pos_x      = cur.pos_x;
    q_item.pos_y      = cur.pos_y;
    q_item.size_x     = cell_mode ? {1'b0, cur.cell_width} : cur.texture_width;
    q_item.size_y     = cell_mode ? {1'b0, cur.cell_height} : cur.texture_height;
    q_item.u0         = cell_mode ? quot[0] : 17'd0;
    q_item.u1         = cell_mode ? quot[1] : TEX_ONE;
    q_item.v0         = cell_mode ? quot[2] : 17'd0;
    q_item.v1         = cell_mode ? quot[3] : TEX_ONE;
  end

endmodule

[rtl/sqb_queue.sv]
// ----------------------------------------------------------------------------
// sqb_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sqb_queue import sqb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  sqb_item_t wr_data,
  output logic      q_full,
  input  logic      rd,
  output sqb_item_t rd_data,
  output logic      q_empty
);

  sqb_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = count == 2'd2;
  assign q_empty = count == 2'd0;
  assign rd_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/sqb_back.sv]
// ----------------------------------------------------------------------------
// sqb_back
// Slot table, batch counters, flush sequencing and result emission.
// ----------------------------------------------------------------------------
module sqb_back import sqb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sqb_item_t q_item,
  input  logic      q_empty,
  output logic      q_pop,
  output sqb_out_t  result,
  output logic      empty,
  input  logic      pop
);

  sqb_back_state_t state, state_next;
  logic [31:0]     slot_textures [TEXTURE_SLOTS];
  logic [3:0]      slots_used;
  logic [15:0]     index_total;
  logic [15:0]     vertex_total;
  logic            ret_look;
  logic [2:0]      bidx;
  logic [1:0]      k;
  logic [2:0]      slot_r;
  logic            out_valid;
  sqb_out_t        out_r;

  logic            emit_ok;
  logic            emit;
  sqb_out_t        emit_data;
  logic            clear_batch;
  logic            add_slot;
  logic            take_hit;
  logic            commit;
  logic            set_ret_look;
  logic            set_ret_done;
  logic            bidx_rst;
  logic            bidx_inc;
  logic            k_rst;
  logic            k_inc;
  logic            hit;
  logic [2:0]      hit_idx;
  logic            right;
  logic            top;
  logic signed [25:0] vx;
  logic signed [25:0] vy;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[23:0];
    end
  endfunction

  assign emit_ok = !out_valid || pop;
  assign empty   = !out_valid;
  assign result  = out_r;

  // slot search, lowest match wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = 3'd0;
    for (int i = TEXTURE_SLOTS - 1; i >= 0; i--) begin
      if (4'(i) < slots_used && slot_textures[i] == q_item.texture_id) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  // vertex corner
  assign right = (k == 2'd1) || (k == 2'd2);
  assign top   = k[1];
  assign vx = right ? 26'(q_item.pos_x) + $signed({6'd0, q_item.size_x, 7'd0})
                    : 26'(q_item.pos_x) - $signed({6'd0, q_item.size_x, 7'd0});
  assign vy = top   ? 26'(q_item.pos_y) + $signed({6'd0, q_item.size_y, 7'd0})
                    : 26'(q_item.pos_y) - $signed({6'd0, q_item.size_y, 7'd0});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!q_empty) state_next = B_START;
      B_START: begin
        case (q_item.kind)
          KIND_SPRITE: state_next = (index_total >= INDEX_BUDGET) ? B_FLUSH : B_LOOK;
          KIND_END:    state_next = B_FLUSH;
          default:     state_next = B_IDLE;
        endcase
      end
      B_FLUSH: begin
        if (vertex_total == 16'd0) begin
          state_next = ret_look ? B_LOOK : B_IDLE;
        end else if (slots_used == 4'd0) begin
          state_next = B_DRAW;
        end else begin
          state_next = B_BIND;
        end
      end
      B_LOOK: begin
        if (!hit && slots_used >= SLOT_COUNT) begin
          state_next = B_FLUSH;
        end else begin
          state_next = B_VERT;
        end
      end
      B_BIND: if (emit_ok && ({1'b0, bidx} + 4'd1) == slots_used) state_next = B_DRAW;
      B_DRAW: if (emit_ok) state_next = ret_look ? B_LOOK : B_IDLE;
      B_VERT: if (emit_ok && k == 2'd3) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs and actions
  always_comb begin
    emit         = 1'b0;
    emit_data    = '0;
    clear_batch  = 1'b0;
    add_slot     = 1'b0;
    take_hit     = 1'b0;
    commit       = 1'b0;
    set_ret_look = 1'b0;
    set_ret_done = 1'b0;
    bidx_rst     = 1'b0;
    bidx_inc     = 1'b0;
    k_rst        = 1'b0;
    k_inc        = 1'b0;
    q_pop        = 1'b0;
    case (state)
      B_START: begin
        bidx_rst = 1'b1;
        case (q_item.kind)
          KIND_SPRITE: set_ret_look = 1'b1;
          KIND_BEGIN: begin
            clear_batch = 1'b1;
            q_pop       = 1'b1;
          end
          KIND_END: set_ret_done = 1'b1;
          default: q_pop = 1'b1;
        endcase
      end
      B_FLUSH: begin
        if (vertex_total == 16'd0) begin
          clear_batch = 1'b1;
          q_pop       = !ret_look;
        end
      end
      B_LOOK: begin
        k_rst    = 1'b1;
        bidx_rst = 1'b1;
        if (hit) begin
          take_hit = 1'b1;
        end else if (slots_used < SLOT_COUNT) begin
          add_slot = 1'b1;
        end
      end
      B_BIND: begin
        if (emit_ok) begin
          emit                    = 1'b1;
          emit_data.out_kind      = OUT_BIND;
          emit_data.slot          = bidx;
          emit_data.bound_texture = slot_textures[bidx];
          bidx_inc                = 1'b1;
        end
      end
      B_DRAW: begin
        if (emit_ok) begin
          emit                   = 1'b1;
          emit_data.out_kind     = OUT_DRAW;
          emit_data.draw_indices = index_total;
          emit_data.last         = !ret_look;
          clear_batch            = 1'b1;
          q_pop                  = !ret_look;
        end
      end
      B_VERT: begin
        if (emit_ok) begin
          emit               = 1'b1;
          emit_data.out_kind = OUT_VERTEX;
          emit_data.vert_x   = sat24(vx);
          emit_data.vert_y   = sat24(vy);
          emit_data.tex_u    = right ? q_item.u1 : q_item.u0;
          emit_data.tex_v    = top ? q_item.v1 : q_item.v0;
          emit_data.slot     = slot_r;
          emit_data.last     = k == 2'd3;
          k_inc              = 1'b1;
          commit             = k == 2'd3;
          q_pop              = k == 2'd3;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      slots_used   <= 4'd0;
      index_total  <= 16'd0;
      vertex_total <= 16'd0;
      out_valid    <= 1'b0;
      ret_look     <= 1'b0;
      bidx         <= 3'd0;
      k            <= 2'd0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (set_ret_look) ret_look <= 1'b1;
      if (set_ret_done) ret_look <= 1'b0;
      if (bidx_rst) begin
        bidx <= 3'd0;
      end else if (bidx_inc) begin
        bidx <= bidx + 3'd1;
      end
      if (k_rst) begin
        k <= 2'd0;
      end else if (k_inc) begin
        k <= k + 2'd1;
      end
      if (clear_batch) begin
        slots_used   <= 4'd0;
        index_total  <= 16'd0;
        vertex_total <= 16'd0;
      end else begin
        if (add_slot) slots_used <= slots_used + 4'd1;
        if (commit) begin
          index_total  <= index_total + 16'd6;
          vertex_total <= vertex_total + 16'd4;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= emit_data;
    end
    if (add_slot) begin
      slot_textures[slots_used[2:0]] <= q_item.texture_id;
      slot_r <= slots_used[2:0];
    end else if (take_hit) begin
      slot_r <= hit_idx;
    end
  end

endmodule

[rtl/sprite_quad_batcher_unit.sv]
// ----------------------------------------------------------------------------
// sprite_quad_batcher_unit
// Front: a cell-mode sprite passes the multiply, load, divide and push states;
// whole-texture sprites and batch markers skip load and divide. The front takes
// a new item only once it has queued the last; the back emits results (4
// vertices, plus slot binds and draw on flush) as its output register frees.
// Reset: synchronous rst clears the batch counters, queue and sequencers.
// ----------------------------------------------------------------------------
module sprite_quad_batcher_unit import sqb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  sqb_in_t  item,
  output logic     empty,
  input  logic     pop,
  output sqb_out_t result
);

  sqb_item_t f_item;
  sqb_item_t b_item;
  logic      f_push;
  logic      q_full;
  logic      q_empty;
  logic      b_pop;

  // classify and compute coordinates
  sqb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (f_push),
    .q_full (q_full),
    .q_item (f_item)
  );

  // decoupling queue
  sqb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data (f_item),
    .q_full  (q_full),
    .rd      (b_pop),
    .rd_data (b_item),
    .q_empty (q_empty)
  );

  // batching and result emission
  sqb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (b_item),
    .q_empty (q_empty),
    .q_pop   (b_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

[dv/tb_sprite_quad_batcher_unit.sv]
// ----------------------------------------------------------------------------
// tb_sprite_quad_batcher_unit
// Self-checking bench for the sprite quad batcher. A short table of directed
// transactions covers field extremes, slot overflow, empty flushes and
// dropped batches. Random batches follow under several idle and stall
// mixes. Every result is checked against an in-bench batch predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sprite_quad_batcher_unit;
  import sqb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     full;
  sqb_in_t  item = '0;
  logic     empty;
  logic     pop = 1'b0;
  sqb_out_t result;

  // directed table row: optional typed first result
  typedef struct {
    sqb_in_t  stim;
    bit       typed;
    sqb_out_t want;
  } table_row_t;

  sqb_out_t   pending_results[$];
  table_row_t directed_rows[$];
  logic [31:0] batch_tex[8];
  int          slots_used;
  int          index_total;
  int          vertex_total;
  logic [31:0] tex_pool[10];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  longint      cycles = 0;

  sprite_quad_batcher_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [23:0] sat24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic logic [16:0] atlas_coord(longint num, longint den);
    longint q;
    if (den == 0) return (num != 0) ? TEX_MAX : 17'd0;
    q = (num << 16) / den;
    return (q > longint'(TEX_MAX)) ? TEX_MAX : q[16:0];
  endfunction

  function automatic void clear_batch();
    slots_used = 0;
    index_total = 0;
    vertex_total = 0;
  endfunction

  function automatic void flush_batch(ref sqb_out_t res[$]);
    sqb_out_t r;
    if (vertex_total != 0) begin
      for (int i = 0; i < slots_used; i++) begin
        r = '0;
        r.out_kind = OUT_BIND;
        r.slot = i[2:0];
        r.bound_texture = batch_tex[i];
        res.push_back(r);
      end
      r = '0;
      r.out_kind = OUT_DRAW;
      r.draw_indices = index_total[15:0];
      res.push_back(r);
    end
    clear_batch();
  endfunction

  // works out the results of one accepted transaction and queues them
  function automatic void predict_quad_results(sqb_in_t it, bit typed, sqb_out_t want);
    sqb_out_t res[$];
    sqb_out_t r;
    bit cell_mode, found, right, top;
    longint sx, sy, px, py, u0, u1, v0, v1, x, y;
    int slot;
    found = 1'b0;
    slot = 0;
    if (it.kind == KIND_BEGIN) begin
      clear_batch();
    end else if (it.kind == KIND_END) begin
      flush_batch(res);
    end else if (it.kind == KIND_SPRITE) begin
      cell_mode = (it.cell_width != 0) || (it.cell_height != 0);
      sx = cell_mode ? longint'(it.cell_width) : longint'(it.texture_width);
      sy = cell_mode ? longint'(it.cell_height) : longint'(it.texture_height);
      px = longint'(it.pos_x);
      py = longint'(it.pos_y);
      if (cell_mode) begin
        u0 = atlas_coord(longint'(it.cell_col) * it.cell_width, it.texture_width);
        u1 = atlas_coord((longint'(it.cell_col) + 1) * it.cell_width, it.texture_width);
        v0 = atlas_coord(longint'(it.cell_row) * it.cell_height, it.texture_height);
        v1 = atlas_coord((longint'(it.cell_row) + 1) * it.cell_height, it.texture_height);
      end else begin
        u0 = 0; u1 = TEX_ONE; v0 = 0; v1 = TEX_ONE;
      end
      // index budget exhausted
      if (index_total >= 6 * MAX_BATCH_QUADS) flush_batch(res);
      for (int i = 0; i < slots_used; i++) begin
        if (!found && batch_tex[i] == it.texture_id) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (slots_used >= TEXTURE_SLOTS) flush_batch(res);
        slot = slots_used;
        batch_tex[slot] = it.texture_id;
        slots_used++;
      end
      // corners: bottom left, bottom right, top right, top left
      for (int k = 0; k < 4; k++) begin
        right = (k == 1 || k == 2);
        top = (k >= 2);
        x = right ? px + sx * 128 : px - sx * 128;
        y = top ? py + sy * 128 : py - sy * 128;
        r = '0;
        r.out_kind = OUT_VERTEX;
        r.vert_x = sat24(x);
        r.vert_y = sat24(y);
        r.tex_u = right ? u1[16:0] : u0[16:0];
        r.tex_v = top ? v1[16:0] : v0[16:0];
        r.slot = slot[2:0];
        res.push_back(r);
      end
      index_total = (index_total + 6) & 16'hFFFF;
      vertex_total = (vertex_total + 4) & 16'hFFFF;
    end
    if (res.size() > 0) begin
      res[res.size() - 1].last = 1'b1;
      if (typed) res[0] = want;
    end
    foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  // ------------------------------------------------------------------ checker
  function automatic void cmp_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    sqb_out_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual %p", $realtime, result);
        end else begin
          e = pending_results.pop_front();
          cmp_field("out_kind", e.out_kind, result.out_kind);
          cmp_field("vert_x", e.vert_x, result.vert_x);
          cmp_field("vert_y", e.vert_y, result.vert_y);
          cmp_field("tex_u", e.tex_u, result.tex_u);
          cmp_field("tex_v", e.tex_v, result.tex_v);
          cmp_field("slot", e.slot, result.slot);
          cmp_field("bound_texture", e.bound_texture, result.bound_texture);
          cmp_field("draw_indices", e.draw_indices, result.draw_indices);
          cmp_field("last", e.last, result.last);
        end
      end
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_transaction(sqb_in_t it, bit typed, sqb_out_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predict_quad_results(it, typed, want);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic sqb_in_t make_sprite(logic [31:0] tex, logic [12:0] tw, logic [12:0] th,
                                          logic [23:0] px, logic [23:0] py,
                                          logic [11:0] cw, logic [11:0] ch,
                                          logic [11:0] col, logic [11:0] row);
    sqb_in_t s;
    s = '0;
    s.kind = KIND_SPRITE;
    s.texture_id = tex;
    s.texture_width = tw;
    s.texture_height = th;
    s.pos_x = px;
    s.pos_y = py;
    s.cell_width = cw;
    s.cell_height = ch;
    s.cell_col = col;
    s.cell_row = row;
    return s;
  endfunction

  function automatic sqb_in_t make_marker(logic [1:0] k);
    sqb_in_t s;
    s = '0;
    s.kind = k;
    return s;
  endfunction

  function automatic void add_row(sqb_in_t s, bit typed = 1'b0, sqb_out_t want = '0);
    table_row_t r;
    r.stim = s;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  function automatic sqb_in_t random_sprite();
    sqb_in_t s;
    s = make_sprite(tex_pool[$urandom_range(0, 9)], 13'($urandom_range(1, 4096)),
                    13'($urandom_range(1, 4096)), 24'($urandom), 24'($urandom),
                    12'd0, 12'd0, 12'($urandom), 12'($urandom));
    // atlas cells half the time, sometimes only one axis or none set, rarely odd texture sizes
    case ($urandom_range(0, 5))
      0: ;
      1: s.cell_width = 12'($urandom);
      2: s.cell_height = 12'($urandom);
      3: begin
        s.cell_width = 12'($urandom_range(1, 64));
        s.cell_height = 12'($urandom_range(1, 64));
        s.cell_col = 12'($urandom_range(0, 63));
        s.cell_row = 12'($urandom_range(0, 63));
      end
      default: begin
        s.cell_width = 12'($urandom);
        s.cell_height = 12'($urandom);
        if ($urandom_range(0, 7) == 0) s.texture_width = 13'($urandom);
        if ($urandom_range(0, 7) == 0) s.texture_height = 13'($urandom);
      end
    endcase
    return s;
  endfunction

  initial begin
    sqb_out_t corner;
    sqb_in_t  s;
    int       sent;
    int       batch_len;

    // reset
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    clear_batch();
    @(posedge clk);

    // directed table
    corner = '0;
    corner.out_kind = OUT_VERTEX;
    corner.vert_x = 24'sh800000;
    corner.vert_y = 24'sh800000;
    s = make_marker(KIND_UNUSED);
    s.texture_id = '1;
    add_row(s);
    add_row(make_marker(KIND_END));
    add_row(make_sprite(32'h0, 13'd4096, 13'd4096, 24'h800000, 24'h800000,
                        12'd0, 12'd0, 12'd0, 12'd0),
            1'b1, corner);
    add_row(make_sprite(32'hFFFF_FFFF, 13'd1, 13'd1, 24'h7FFFFF, 24'h7FFFFF,
                        12'd0, 12'd0, 12'd0, 12'd0));
    add_row(make_sprite(32'hA5A5_0001, 13'd1, 13'd4096, 24'h0, 24'h0,
                        12'hFFF, 12'h0, 12'hFFF, 12'h0));
    add_row(make_sprite(32'h5A5A_0002, 13'd0, 13'd0, 24'hFFFF00, 24'h000100,
                        12'd5, 12'd5, 12'd0, 12'd3));
    add_row(make_sprite(32'h0, 13'h1FFF, 13'h1FFF, 24'h000080, 24'hFFFF80,
                        12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    for (int i = 3; i < 9; i++)
      add_row(make_sprite(32'h1000 + i, 13'd64, 13'd32, 24'(i * 256), 24'(-i * 256),
                          12'd16, 12'd8, 12'(i), 12'(i)));
    add_row(make_marker(KIND_END));
    add_row(make_sprite(32'h77, 13'd16, 13'd16, 24'h0, 24'h0,
                        12'd0, 12'd0, 12'd0, 12'd0));
    add_row(make_marker(KIND_BEGIN));
    add_row(make_marker(KIND_END));
    add_row(make_marker(KIND_UNUSED));
    foreach (directed_rows[i])
      send_transaction(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    // random batches under four idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 65 : 35) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 65 : 35) : 0;
      foreach (tex_pool[i]) tex_pool[i] = $urandom;
      sent = 0;
      while (sent < 36) begin
        // well-formed batch most of the time, noise otherwise
        if ($urandom_range(0, 3) != 0) begin
          send_transaction(make_marker(KIND_BEGIN), 1'b0, '0);
          sent++;
        end
        batch_len = $urandom_range(1, 12);
        for (int j = 0; j < batch_len; j++) begin
          send_transaction(random_sprite(), 1'b0, '0);
          sent++;
        end
        case ($urandom_range(0, 9))
          0: s = make_marker(KIND_BEGIN);
          1: s = make_marker(KIND_UNUSED);
          default: s = make_marker(KIND_END);
        endcase
        s.texture_id = $urandom;
        send_transaction(s, 1'b0, '0);
        sent++;
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/sqb_pkg.sv
rtl/sqb_div.sv
rtl/sqb_front.sv
rtl/sqb_queue.sv
rtl/sqb_back.sv
rtl/sprite_quad_batcher_unit.sv
dv/tb_sprite_quad_batcher_unit.sv
